// ----- rtl/mbet_pkg.sv -----
// Shared types, widths, register indexes and fixed-point helpers for the Mandelbrot pixel block.
package mbet_pkg;

  // Q4.FRAC_BITS fixed point: sign, four integer bits, fraction
  localparam int FRAC_BITS  = 27;
  localparam int QW         = FRAC_BITS + 5;
  localparam int STEP_W     = FRAC_BITS + 1;
  localparam int PROD_W     = 2 * QW - FRAC_BITS;
  localparam int SAT_W      = STEP_W + 20;
  localparam int CNT_W      = 8;
  localparam int COLOUR_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_COLOUR = CFG_IDX_W'(4);

  // Register reset values
  localparam logic [STEP_W-1:0]   STEP_RESET = STEP_W'(671089);
  localparam logic [CNT_W-1:0]    ITER_RESET = CNT_W'(100);
  localparam logic [COLOUR_W-1:0] COLOUR_INC = COLOUR_W'(15);

  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam q_t Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(QW-1){1'b0}}};

  // Escape bound: |z|^2 may not exceed 4.0
  localparam logic signed [PROD_W:0] ESC_LIMIT = (PROD_W+1)'(64'd4 << FRAC_BITS);

  // Settings the iteration engine reads
  typedef struct packed {
    logic [CNT_W-1:0]    max_iter;
    logic [COLOUR_W-1:0] base_colour;
  } bk_cfg_t;

  // Iteration engine status
  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] count;
  } bk_stat_t;

  // Clamp a wide signed value onto the Q4 range
  function automatic q_t sat_q(input logic signed [SAT_W-1:0] v);
    logic [SAT_W-QW:0] hi;
    hi = v[SAT_W-1:QW-1];
    if ((&hi) || !(|hi)) begin
      return $signed(v[QW-1:0]);
    end else if (v[SAT_W-1]) begin
      return Q_MIN;
    end else begin
      return Q_MAX;
    end
  endfunction

endpackage

// ----- rtl/mbet_if.sv -----
// Handshake interfaces for pixel input, result output and configuration writes.
interface mbet_pix_if #(parameter int PIXEL_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_col;
  logic [PIXEL_BITS-1:0] pixel_row;
  modport source (output valid, pixel_col, pixel_row, input ready);
  modport sink   (input valid, pixel_col, pixel_row, output ready);
endinterface

interface mbet_res_if import mbet_pkg::*; #(parameter int PIXEL_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] out_col;
  logic [PIXEL_BITS-1:0] out_row;
  logic [CNT_W-1:0]      iteration_count;
  logic [COLOUR_W-1:0]   colour_word;
  modport source (output valid, out_col, out_row, iteration_count, colour_word, input ready);
  modport sink   (input valid, out_col, out_row, iteration_count, colour_word, output ready);
endinterface

interface mbet_cfg_if import mbet_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/mandelbrot_escape_time_pixel.sv -----
// Top level of the Mandelbrot escape-time pixel evaluator.
//
//   Port     Dir  Transaction
//   in_pix   in   pixel_col, pixel_row of one point to evaluate
//   out_res  out  out_col, out_row, iteration_count, colour_word
//   cfg_wr   in   index, data; writes one setting, always ready
//
// A pixel passes the front-end holding register and the queue; the engine
// then loads it, runs a multiply state and an update state per iteration on
// its three multipliers (one more pair for the escape test) and registers
// the result in a finish state. The default iteration limit is 100. A
// two-entry queue keeps the front end taking pixels while the engine is busy
// or a result waits. Reset is synchronous, active low, and restores the
// register defaults.
module mandelbrot_escape_time_pixel import mbet_pkg::*; #(
  parameter int PIXEL_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  mbet_pix_if.sink    in_pix,
  mbet_res_if.source  out_res,
  mbet_cfg_if.sink    cfg_wr
);

  localparam int ITEM_W = 2 * PIXEL_BITS + 2 * QW;

  logic [PIXEL_BITS-1:0] origin_x_r;
  logic [PIXEL_BITS-1:0] origin_y_r;
  logic [STEP_W-1:0]     pixel_step_r;
  logic [CNT_W-1:0]      max_iter_r;
  logic [COLOUR_W-1:0]   base_colour_r;

  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_empty;
  logic [ITEM_W-1:0]     q_wdata;
  logic [ITEM_W-1:0]     q_rdata;
  bk_cfg_t               bk_cfg;
  bk_stat_t              bk_stat;

  assign cfg_wr.ready = 1'b1;

  // Decode configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      pixel_step_r  <= STEP_RESET;
      max_iter_r    <= ITER_RESET;
      base_colour_r <= '0;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        CFG_ORIGIN_X:    origin_x_r    <= cfg_wr.data[PIXEL_BITS-1:0];
        CFG_ORIGIN_Y:    origin_y_r    <= cfg_wr.data[PIXEL_BITS-1:0];
        CFG_PIXEL_STEP:  pixel_step_r  <= cfg_wr.data[STEP_W-1:0];
        CFG_MAX_ITER:    max_iter_r    <= cfg_wr.data[CNT_W-1:0];
        CFG_BASE_COLOUR: base_colour_r <= cfg_wr.data[COLOUR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign bk_cfg.max_iter    = max_iter_r;
  assign bk_cfg.base_colour = base_colour_r;

  // Map positions onto the plane
  mbet_front #(.PIXEL_BITS(PIXEL_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_pix     (in_pix),
    .origin_x   (origin_x_r),
    .origin_y   (origin_y_r),
    .pixel_step (pixel_step_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  // Decouple front end and engine
  mbet_queue #(.W(ITEM_W), .DEPTH(2)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // Iterate and deliver results
  mbet_core #(.PIXEL_BITS(PIXEL_BITS)) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_rdata (q_rdata),
    .q_pop   (q_pop),
    .cfg     (bk_cfg),
    .out_res (out_res),
    .stat    (bk_stat)
  );

  // The running count never passes the limit
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.busy |-> (bk_stat.count <= max_iter_r))
    else $error("iteration count beyond limit");

  // A delivered count stays within the limit
  a_out_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> (out_res.iteration_count <= max_iter_r))
    else $error("result count beyond limit");

  // Colour word follows the count and the base colour
  a_colour: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> (out_res.colour_word == (base_colour_r
      + ((COLOUR_W'(out_res.iteration_count) * COLOUR_INC) << 8))))
    else $error("colour word does not match count");

  // The engine never loads from an empty queue
  a_pop_guard: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty && !bk_stat.busy)
    else $error("pop without a queued pixel");

endmodule

// ----- rtl/mbet_front.sv -----
// Front end: accepts pixel positions and maps them onto the complex plane.
module mbet_front import mbet_pkg::*; #(
  parameter int PIXEL_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mbet_pix_if.sink                      in_pix,
  input  logic [PIXEL_BITS-1:0]         origin_x,
  input  logic [PIXEL_BITS-1:0]         origin_y,
  input  logic [STEP_W-1:0]             pixel_step,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [2*PIXEL_BITS+2*QW-1:0]  q_wdata
);

  localparam int MUL_W = PIXEL_BITS + STEP_W + 2;

  logic                          valid_r;
  logic [PIXEL_BITS-1:0]         col_r;
  logic [PIXEL_BITS-1:0]         row_r;
  logic                          accept;
  logic signed [PIXEL_BITS:0]    dx;
  logic signed [PIXEL_BITS:0]    dy;
  logic signed [MUL_W-1:0]       px;
  logic signed [MUL_W-1:0]       py;
  q_t                            cr;
  q_t                            ci;

  // Take a new transaction when the holding stage is empty or draining
  assign in_pix.ready = !valid_r || !q_full;
  assign accept       = in_pix.valid && in_pix.ready;
  assign q_push       = valid_r && !q_full;

  // Scale pixel offsets by the step and clamp onto the Q4 range
  always_comb begin
    dx = $signed({1'b0, col_r}) - $signed({1'b0, origin_x});
    dy = $signed({1'b0, row_r}) - $signed({1'b0, origin_y});
    px = dx * $signed({1'b0, pixel_step});
    py = dy * $signed({1'b0, pixel_step});
    cr = sat_q(SAT_W'(px));
    ci = sat_q(SAT_W'(py));
  end

  assign q_wdata = {col_r, row_r, cr, ci};

  // Hold the accepted position until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      if (accept) begin
        valid_r <= 1'b1;
        col_r   <= in_pix.pixel_col;
        row_r   <= in_pix.pixel_row;
      end else if (q_push) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/mbet_queue.sv -----
// Short first-in first-out queue between the front end and the iteration engine.
module mbet_queue #(
  parameter int W     = 88,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]     entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;

  assign full  = (count_r == (PTR_W+1)'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        entry_r[wr_ptr_r] <= wdata;
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (PTR_W+1)'(1);
      end
    end
  end

endmodule

// ----- rtl/mbet_core.sv -----
// Iteration engine: runs z = z^2 + c to escape or limit and forms the result.
module mbet_core import mbet_pkg::*; #(
  parameter int PIXEL_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  logic [2*PIXEL_BITS+2*QW-1:0]  q_rdata,
  output logic                          q_pop,
  input  bk_cfg_t                       cfg,
  mbet_res_if.source                    out_res,
  output bk_stat_t                      stat
);

  localparam int SUM_W = PROD_W + 2;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_UPD, ST_FIN} state_t;

  state_t                state_r;
  logic [PIXEL_BITS-1:0] col_r;
  logic [PIXEL_BITS-1:0] row_r;
  q_t                    cr_r;
  q_t                    ci_r;
  q_t                    zr_r;
  q_t                    zi_r;
  logic [CNT_W-1:0]      cnt_r;
  prod_t                 rr_r;
  prod_t                 ii_r;
  prod_t                 ri_r;
  logic                  out_valid_r;
  logic [PIXEL_BITS-1:0] out_col_r;
  logic [PIXEL_BITS-1:0] out_row_r;
  logic [CNT_W-1:0]      out_cnt_r;
  logic [COLOUR_W-1:0]   out_colour_r;

  logic signed [2*QW-1:0]  p_rr;
  logic signed [2*QW-1:0]  p_ii;
  logic signed [2*QW-1:0]  p_ri;
  logic signed [PROD_W:0]  mag_sum;
  logic signed [SUM_W-1:0] nr_sum;
  logic signed [SUM_W-1:0] ni_sum;
  logic                    escape;
  logic [CNT_W-1:0]        cnt_inc;
  logic [CNT_W+3:0]        cnt15;
  logic [COLOUR_W-1:0]     colour;

  // Three full products of the current z
  assign p_rr = zr_r * zr_r;
  assign p_ii = zi_r * zi_r;
  assign p_ri = zr_r * zi_r;

  // Escape test and next z from the registered, floored products; next count and colour word
  always_comb begin
    mag_sum = (PROD_W+1)'(rr_r) + (PROD_W+1)'(ii_r);
    escape  = mag_sum > ESC_LIMIT;
    nr_sum  = SUM_W'(rr_r) - SUM_W'(ii_r) + SUM_W'(cr_r);
    ni_sum  = (SUM_W'(ri_r) <<< 1) + SUM_W'(ci_r);
    cnt_inc = cnt_r + CNT_W'(1);
    cnt15   = {cnt_r, 4'b0000} - (CNT_W+4)'(cnt_r);
    colour  = cfg.base_colour + (COLOUR_W'(cnt15) << 8);
  end

  assign q_pop = (state_r == ST_IDLE) && !q_empty;

  assign out_res.valid           = out_valid_r;
  assign out_res.out_col         = out_col_r;
  assign out_res.out_row         = out_row_r;
  assign out_res.iteration_count = out_cnt_r;
  assign out_res.colour_word     = out_colour_r;

  assign stat.busy  = (state_r != ST_IDLE);
  assign stat.count = cnt_r;

  // Sequence one pixel: load, multiply, update, deliver
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // Drop a delivered result unless a new one replaces it
      if (out_valid_r && out_res.ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            {col_r, row_r, cr_r, ci_r} <= q_rdata;
            zr_r    <= $signed(q_rdata[2*QW-1:QW]);
            zi_r    <= $signed(q_rdata[QW-1:0]);
            cnt_r   <= '0;
            state_r <= (cfg.max_iter == '0) ? ST_FIN : ST_MUL;
          end
        end
        ST_MUL: begin
          rr_r    <= $signed(p_rr[2*QW-1:FRAC_BITS]);
          ii_r    <= $signed(p_ii[2*QW-1:FRAC_BITS]);
          ri_r    <= $signed(p_ri[2*QW-1:FRAC_BITS]);
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          if (escape) begin
            state_r <= ST_FIN;
          end else begin
            zr_r    <= sat_q(SAT_W'(nr_sum));
            zi_r    <= sat_q(SAT_W'(ni_sum));
            cnt_r   <= cnt_inc;
            state_r <= (cnt_inc == cfg.max_iter) ? ST_FIN : ST_MUL;
          end
        end
        ST_FIN: begin
          if (!out_valid_r || out_res.ready) begin
            out_valid_r  <= 1'b1;
            out_col_r    <= col_r;
            out_row_r    <= row_r;
            out_cnt_r    <= cnt_r;
            out_colour_r <= colour;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sim/testbench.sv -----
// Testbench for the Mandelbrot pixel block: directed vectors, then random views checked by a predictor.
`timescale 1ns / 100ps

module testbench;
  import mbet_pkg::*;

  localparam int PIXEL_BITS   = 12;
  localparam int ORIGIN_W     = PIXEL_BITS;
  localparam int RESET_CYCLES = 6;
  localparam int MAX_GAP      = 17;
  localparam int HOLD_AT      = 80;
  localparam int HOLD_CYCLES  = 1500;
  localparam int NUM_PHASES   = 12;
  localparam int TAIL_CYCLES  = 2 * 255 + 16;
  localparam int CYCLE_LIMIT  = 3_000_000;

  localparam longint Q_HI         = longint'(Q_MAX);
  localparam longint Q_LO         = longint'(Q_MIN);
  localparam longint ESCAPE_BOUND = longint'(4) << FRAC_BITS;

  localparam logic [STEP_W-1:0]    STEP_ONE      = STEP_W'(1) << FRAC_BITS;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_BASE_COLOUR + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST  = '1;

  typedef enum logic {VEC_REG, VEC_PIX} vector_kind_t;

  // One directed row: a register write, or a pixel with an optional typed-in result
  typedef struct packed {
    vector_kind_t          kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    logic [PIXEL_BITS-1:0] col;
    logic [PIXEL_BITS-1:0] row;
    logic                  typed;
    logic [CNT_W-1:0]      count;
    logic [COLOUR_W-1:0]   colour;
  } directed_vector_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] col;
    logic [PIXEL_BITS-1:0] row;
    logic [CNT_W-1:0]      count;
    logic [COLOUR_W-1:0]   colour;
  } pixel_result_t;

  localparam int NUM_DIRECTED = 43;

  directed_vector_t directed_vectors [NUM_DIRECTED] = '{
    // defaults after reset: origin at the corner, step about 1/200
    '{VEC_PIX, '0, '0, 12'd0,    12'd0,    1'b1, 8'd100, 32'h0005_DC00},
    '{VEC_PIX, '0, '0, 12'd4095, 12'd4095, 1'b1, 8'd0,   32'h0000_0000},
    '{VEC_PIX, '0, '0, 12'd0,    12'd4095, 1'b1, 8'd0,   32'h0000_0000},
    '{VEC_PIX, '0, '0, 12'd4095, 12'd0,    1'b1, 8'd0,   32'h0000_0000},
    '{VEC_PIX, '0, '0, 12'd100,  12'd50,   1'b0, '0,     '0},
    // centre the origin, with junk above the field width
    '{VEC_REG, CFG_ORIGIN_X, 32'hFFFF_F800, '0, '0, 1'b0, '0, '0},
    '{VEC_REG, CFG_ORIGIN_Y, 32'h0000_1800, '0, '0, 1'b0, '0, '0},
    '{VEC_PIX, '0, '0, 12'd2048, 12'd2048, 1'b1, 8'd100, 32'h0005_DC00},
    '{VEC_PIX, '0, '0, 12'd0,    12'd0,    1'b1, 8'd0,   32'h0000_0000},
    '{VEC_PIX, '0, '0, 12'd4095, 12'd4095, 1'b1, 8'd0,   32'h0000_0000},
    '{VEC_PIX, '0, '0, 12'd2100, 12'd2030, 1'b0, '0,     '0},
    // largest limit, all-ones base colour: colour wraps
    '{VEC_REG, CFG_MAX_ITER,    32'hFFFF_FFFF, '0, '0, 1'b0, '0, '0},
    '{VEC_REG, CFG_BASE_COLOUR, 32'hFFFF_FFFF, '0, '0, 1'b0, '0, '0},
    '{VEC_PIX, '0, '0, 12'd2048, 12'd2048, 1'b1, 8'd255, 32'h000E_F0FF},
    // zero step puts every pixel on the origin
    '{VEC_REG, CFG_PIXEL_STEP, 32'h0000_0000, '0, '0, 1'b0, '0, '0},
    '{VEC_PIX, '0, '0, 12'd0,    12'd4095, 1'b1, 8'd255, 32'h000E_F0FF},
    // zero limit: no iteration at all
    '{VEC_REG, CFG_MAX_ITER, 32'h1234_5600, '0, '0, 1'b0, '0, '0},
    '{VEC_PIX, '0, '0, 12'd2048, 12'd2048, 1'b1, 8'd0,   32'hFFFF_FFFF},
    // writes to unused indexes must change nothing
    '{VEC_REG, CFG_IDX_SPARE, 32'h0000_0001, '0, '0, 1'b0, '0, '0},
    '{VEC_REG, CFG_IDX_LAST,  32'hFFFF_FFFF, '0, '0, 1'b0, '0, '0},
    '{VEC_PIX, '0, '0, 12'd1,    12'd1,    1'b1, 8'd0,   32'hFFFF_FFFF},
    // step of one: c = 2 sits exactly on the escape bound
    '{VEC_REG, CFG_MAX_ITER,    32'h0000_0001, '0, '0, 1'b0, '0, '0},
    '{VEC_REG, CFG_PIXEL_STEP,  32'h0800_0000, '0, '0, 1'b0, '0, '0},
    '{VEC_REG, CFG_BASE_COLOUR, 32'h0000_0000, '0, '0, 1'b0, '0, '0},
    '{VEC_PIX, '0, '0, 12'd2048, 12'd2048, 1'b1, 8'd1,   32'h0000_0F00},
    '{VEC_PIX, '0, '0, 12'd2050, 12'd2048, 1'b1, 8'd1,   32'h0000_0F00},
    '{VEC_PIX, '0, '0, 12'd2051, 12'd2048, 1'b1, 8'd0,   32'h0000_0000},
    // widest step: far pixels saturate
    '{VEC_REG, CFG_PIXEL_STEP, 32'hFFFF_FFFF, '0, '0, 1'b0, '0, '0},
    '{VEC_REG, CFG_MAX_ITER,   32'h0000_0014, '0, '0, 1'b0, '0, '0},
    '{VEC_PIX, '0, '0, 12'd2049, 12'd2047, 1'b0, '0,     '0},
    '{VEC_PIX, '0, '0, 12'd0,    12'd0,    1'b1, 8'd0,   32'h0000_0000},
    '{VEC_PIX, '0, '0, 12'd4095, 12'd4095, 1'b1, 8'd0,   32'h0000_0000},
    // smallest step, carry out of the green byte
    '{VEC_REG, CFG_PIXEL_STEP,  32'h0000_0001, '0, '0, 1'b0, '0, '0},
    '{VEC_REG, CFG_MAX_ITER,    32'h0000_00C8, '0, '0, 1'b0, '0, '0},
    '{VEC_REG, CFG_BASE_COLOUR, 32'hFF00_FF00, '0, '0, 1'b0, '0, '0},
    '{VEC_PIX, '0, '0, 12'd4095, 12'd0,    1'b0, '0,     '0},
    '{VEC_PIX, '0, '0, 12'd1,    12'd2,    1'b0, '0,     '0},
    // origin at the far corner, step of 1/32
    '{VEC_REG, CFG_ORIGIN_X,   32'h0000_0FFF, '0, '0, 1'b0, '0, '0},
    '{VEC_REG, CFG_ORIGIN_Y,   32'h0000_0000, '0, '0, 1'b0, '0, '0},
    '{VEC_REG, CFG_PIXEL_STEP, 32'h0040_0000, '0, '0, 1'b0, '0, '0},
    '{VEC_REG, CFG_MAX_ITER,   32'h0000_0032, '0, '0, 1'b0, '0, '0},
    '{VEC_PIX, '0, '0, 12'd4031, 12'd10,   1'b0, '0,     '0},
    '{VEC_PIX, '0, '0, 12'd4035, 12'd4095, 1'b0, '0,     '0}
  };

  logic clk;
  logic rst_n;

  mbet_pix_if #(.PIXEL_BITS(PIXEL_BITS)) pix_bus ();
  mbet_res_if #(.PIXEL_BITS(PIXEL_BITS)) res_bus ();
  mbet_cfg_if                            cfg_bus ();

  mandelbrot_escape_time_pixel #(
    .PIXEL_BITS(PIXEL_BITS)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_bus.sink),
    .out_res (res_bus.source),
    .cfg_wr  (cfg_bus.sink)
  );

  // Predictor copy of the settings
  logic [ORIGIN_W-1:0] origin_col   = '0;
  logic [ORIGIN_W-1:0] origin_row   = '0;
  logic [STEP_W-1:0]   plane_step   = STEP_RESET;
  logic [CNT_W-1:0]    iter_limit   = ITER_RESET;
  logic [COLOUR_W-1:0] colour_base  = '0;

  pixel_result_t awaited_pixels[$];
  int unsigned   error_count  = 0;
  int unsigned   results_seen = 0;
  bit            steady_phase = 1'b0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Clamp onto the Q4 range
  function automatic longint clamp_q(input longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  // Exact product, floored to the fraction width
  function automatic longint q_mul(input longint a, input longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic longint plane_coord(input logic [ORIGIN_W-1:0] pix,
                                         input logic [ORIGIN_W-1:0] org);
    return clamp_q((longint'(pix) - longint'(org)) * longint'(plane_step));
  endfunction

  // Escape count and colour of one pixel under the current settings
  function automatic pixel_result_t escape_time(input logic [PIXEL_BITS-1:0] col,
                                                input logic [PIXEL_BITS-1:0] row);
    pixel_result_t res;
    longint        cr, ci, zr, zi, rr, ii, ri;
    int unsigned   n;
    cr = plane_coord(col, origin_col);
    ci = plane_coord(row, origin_row);
    zr = cr;
    zi = ci;
    n  = 0;
    while (n < iter_limit) begin
      rr = q_mul(zr, zr);
      ii = q_mul(zi, zi);
      if (rr + ii > ESCAPE_BOUND) break;
      ri = q_mul(zr, zi);
      zr = clamp_q(rr - ii + cr);
      zi = clamp_q(2 * ri + ci);
      n++;
    end
    res.col    = col;
    res.row    = row;
    res.count  = CNT_W'(n);
    res.colour = colour_base + ((COLOUR_W'(n) * COLOUR_INC) << 8);
    return res;
  endfunction

  function automatic int unsigned draw_gap();
    if (steady_phase) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // Drain, then write one setting; valid stays high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    pix_bus.valid <= 1'b0;
    while (awaited_pixels.size() != 0) @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (index)
      CFG_ORIGIN_X:    origin_col  = data[ORIGIN_W-1:0];
      CFG_ORIGIN_Y:    origin_row  = data[ORIGIN_W-1:0];
      CFG_PIXEL_STEP:  plane_step  = data[STEP_W-1:0];
      CFG_MAX_ITER:    iter_limit  = data[CNT_W-1:0];
      CFG_BASE_COLOUR: colour_base = data[COLOUR_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one pixel after a random gap; record its result once accepted
  task automatic send_pixel(input logic [PIXEL_BITS-1:0] col, input logic [PIXEL_BITS-1:0] row,
                            input pixel_result_t want);
    int unsigned gap;
    gap = draw_gap();
    cfg_bus.valid <= 1'b0;
    if (gap != 0) begin
      pix_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_bus.valid     <= 1'b1;
    pix_bus.pixel_col <= col;
    pix_bus.pixel_row <= row;
    do @(posedge clk); while (!pix_bus.ready);
    awaited_pixels.push_back(want);
  endtask

  // Stimulus: reset, directed vectors, then random views
  initial begin : stimulus
    int unsigned           items, span;
    int                    view_x, view_y;
    logic [STEP_W-1:0]     step;
    logic [CNT_W-1:0]      limit;
    logic [31:0]           junk;
    logic [PIXEL_BITS-1:0] col, row;
    pixel_result_t         want;
    directed_vector_t      vec;
    rst_n             <= 1'b0;
    pix_bus.valid     <= 1'b0;
    pix_bus.pixel_col <= '0;
    pix_bus.pixel_row <= '0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= CFG_ORIGIN_X;
    cfg_bus.data      <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_vectors[v]) begin
      vec = directed_vectors[v];
      if (vec.kind == VEC_REG) begin
        write_reg(vec.index, vec.data);
      end else begin
        if (vec.typed) begin
          want.col    = vec.col;
          want.row    = vec.row;
          want.count  = vec.count;
          want.colour = vec.colour;
        end else begin
          want = escape_time(vec.col, vec.row);
        end
        send_pixel(vec.col, vec.row, want);
      end
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // Pick a view: span pixels cover the plane from -2 to 2
      span   = 1 << $urandom_range(6, 12);
      step   = STEP_W'((longint'(4) << FRAC_BITS) / span);
      limit  = CNT_W'($urandom_range(1, 64));
      view_x = $urandom_range(0, (1 << ORIGIN_W) - 1);
      view_y = $urandom_range(0, (1 << ORIGIN_W) - 1);
      if ($urandom_range(0, 5) == 0) step = STEP_W'($urandom());
      case (phase)
        0: limit = '1;
        1: limit = CNT_W'(1);
        2: step  = '1;
        3: step  = STEP_ONE;
        4: limit = '0;
        5: step  = '0;
        default: ;
      endcase
      items = (phase == 0) ? 40 : 100;

      // Write every setting, with junk above each narrower field, then one unused index
      junk = $urandom();
      write_reg(CFG_ORIGIN_X, {junk[CFG_DATA_W-1:ORIGIN_W], ORIGIN_W'(view_x)});
      write_reg(CFG_ORIGIN_Y, {junk[CFG_DATA_W-1:ORIGIN_W], ORIGIN_W'(view_y)});
      write_reg(CFG_PIXEL_STEP, {junk[CFG_DATA_W-1:STEP_W], step});
      write_reg(CFG_MAX_ITER, {junk[CFG_DATA_W-1:CNT_W], limit});
      write_reg(CFG_BASE_COLOUR, (phase == 6) ? '1 : $urandom());
      write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_SPARE, CFG_IDX_LAST)), $urandom());
      steady_phase = (phase % 4 == 3);

      // Mostly pixels inside the view, some anywhere
      for (int k = 0; k < items; k++) begin
        if ($urandom_range(0, 99) < 85) begin
          col = PIXEL_BITS'(view_x + $urandom_range(0, span) - span / 2);
          row = PIXEL_BITS'(view_y + $urandom_range(0, span) - span / 2);
        end else begin
          col = PIXEL_BITS'($urandom());
          row = PIXEL_BITS'($urandom());
        end
        send_pixel(col, row, escape_time(col, row));
      end
    end

    // Drain, then watch for stray results
    pix_bus.valid <= 1'b0;
    while (awaited_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("** mandelbrot_escape_time_pixel: PASSED **");
    end else begin
      $display("** mandelbrot_escape_time_pixel: FAILED **");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off, field-by-field check
  initial begin : result_sink
    int unsigned   gap;
    bit            held;
    pixel_result_t want;
    held = 1'b0;
    res_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (results_seen == HOLD_AT && !held) begin
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end else begin
        gap = draw_gap();
      end
      if (gap != 0) begin
        res_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk); while (!res_bus.valid);
      results_seen++;
      if (awaited_pixels.size() == 0) begin
        $error("unexpected result: col %0d row %0d count %0d",
               res_bus.out_col, res_bus.out_row, res_bus.iteration_count);
        error_count++;
      end else begin
        want = awaited_pixels.pop_front();
        check_field("out_col", 32'(want.col), 32'(res_bus.out_col));
        check_field("out_row", 32'(want.row), 32'(res_bus.out_row));
        check_field("iteration_count", 32'(want.count), 32'(res_bus.iteration_count));
        check_field("colour_word", want.colour, res_bus.colour_word);
      end
    end
  end

  // Guard against a hung run
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** mandelbrot_escape_time_pixel: FAILED **");
    $finish;
  end

endmodule

// ----- mandelbrot_escape_time_pixel.f -----
rtl/mbet_pkg.sv
rtl/mbet_if.sv
rtl/mbet_front.sv
rtl/mbet_queue.sv
rtl/mbet_core.sv
rtl/mandelbrot_escape_time_pixel.sv
sim/testbench.sv
